FILE: rtl/h2ps_pkg.sv
// shared types, constants and translation tables for the hid to ps/2 scan code transmitter
package h2ps_pkg;

   localparam int KEYCODE_W   = 16;
   localparam int BYTE_W      = 8;
   localparam int FRAME_W     = 11;
   localparam int ENTRY_W     = 9;

   localparam int ROM_A_SIZE  = 145;
   localparam int ROM_B_SIZE  = 44;
   localparam int ROM_A_IDX_W = $clog2(ROM_A_SIZE);
   localparam int ROM_B_IDX_W = $clog2(ROM_B_SIZE);

   localparam logic [KEYCODE_W-1:0] ROM_A_FIRST = 16'h0004;
   localparam logic [KEYCODE_W-1:0] ROM_A_LAST  = 16'h0094;
   localparam logic [KEYCODE_W-1:0] ROM_B_FIRST = 16'h00E0;
   localparam logic [KEYCODE_W-1:0] ROM_B_LAST  = 16'h010B;

   localparam logic [BYTE_W-1:0]  PREFIX_EXT   = 8'hE0;
   localparam logic [BYTE_W-1:0]  PREFIX_BREAK = 8'hF0;
   localparam logic [ENTRY_W-1:0] NO_CODE      = 9'h000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // bit 8 asks for the extended prefix, bits 7..0 are the scan code
   localparam logic [ENTRY_W-1:0] ROM_A [ROM_A_SIZE] = '{
      9'h01c, 9'h032, 9'h021, 9'h023, 9'h024, 9'h02b, 9'h034, 9'h033, 9'h043, 9'h03b,
      9'h042, 9'h04b, 9'h03a, 9'h031, 9'h044, 9'h04d, 9'h015, 9'h02d, 9'h01b, 9'h02c,
      9'h03c, 9'h02a, 9'h01d, 9'h022, 9'h035, 9'h01a, 9'h016, 9'h01e, 9'h026, 9'h025,
      9'h02e, 9'h036, 9'h03d, 9'h03e, 9'h046, 9'h045, 9'h05a, 9'h076, 9'h066, 9'h00d,
      9'h029, 9'h04e, 9'h055, 9'h054, 9'h05b, 9'h05d, 9'h05d, 9'h04c, 9'h052, 9'h00e,
      9'h041, 9'h049, 9'h04a, 9'h058, 9'h005, 9'h006, 9'h004, 9'h00c, 9'h003, 9'h00b,
      9'h083, 9'h00a, 9'h001, 9'h009, 9'h078, 9'h007, 9'h17c, 9'h07e, 9'h17e, 9'h170,
      9'h16c, 9'h17d, 9'h171, 9'h179, 9'h17a, 9'h174, 9'h16b, 9'h172, 9'h175, 9'h077,
      9'h14a, 9'h07c, 9'h07b, 9'h079, 9'h15a, 9'h069, 9'h072, 9'h07a, 9'h06b, 9'h073,
      9'h074, 9'h06c, 9'h075, 9'h07d, 9'h070, 9'h071, 9'h061, 9'h12f, 9'h137, 9'h00f,
      9'h008, 9'h010, 9'h018, 9'h020, 9'h028, 9'h030, 9'h038, 9'h040, 9'h048, 9'h050,
      9'h057, 9'h05f, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h06d,
      9'h000, 9'h051, 9'h013, 9'h06a, 9'h064, 9'h067, 9'h027, 9'h000, 9'h000, 9'h000,
      9'h0f2, 9'h0f1, 9'h063, 9'h062, 9'h05f
   };

   localparam logic [ENTRY_W-1:0] ROM_B [ROM_B_SIZE] = '{
      9'h014, 9'h012, 9'h011, 9'h11f, 9'h114, 9'h059, 9'h111, 9'h127,
      9'h000, 9'h14d, 9'h115, 9'h13b, 9'h134, 9'h123, 9'h000, 9'h000,
      9'h132, 9'h121, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h150, 9'h148, 9'h12b, 9'h140, 9'h110, 9'h13a, 9'h138, 9'h130, 9'h128, 9'h120,
      9'h000, 9'h047, 9'h04f, 9'h065, 9'h068, 9'h06e, 9'h147, 9'h14f, 9'h165, 9'h167,
      9'h168, 9'h16a
   };

   // classified key event waiting to be sent
   typedef struct packed {
      logic              ext;
      logic              brk;
      logic [BYTE_W-1:0] code;
   } h2ps_event_type;

   // start 0, data lsb first, odd parity, stop 1
   function automatic logic [FRAME_W-1:0] make_frame(input logic [BYTE_W-1:0] b);
      return {1'b1, ~(^b), b, 1'b0};
   endfunction

endpackage

FILE: rtl/h2ps_req_if.sv
// key event channel: valid, ready and the event payload
interface h2ps_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] keycode;
   logic        pressed;

   modport source (output valid, output keycode, output pressed, input ready);
   modport sink   (input valid, input keycode, input pressed, output ready);
endinterface

FILE: rtl/h2ps_rsp_if.sv
// scan code byte channel: valid, ready and the byte with its ps/2 frame
interface h2ps_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [10:0] frame_bits;
   logic        last;

   modport source (output valid, output data_byte, output frame_bits, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input frame_bits, input last,
                   output ready);
endinterface

FILE: rtl/hid_to_ps2_scancode_tx_unit.sv
// top level of the hid keycode to ps/2 set 2 scan code transmitter
// the first byte of an event passes the front register, a queue slot, the current event
// register and the output register; throughput: one byte per cycle from the back end while
//   rsp is ready, 1 to 3 bytes per event; unmapped keys are taken and send nothing
// the event queue (4 deep) lets the front keep taking events while bytes stall
// reset: synchronous, active high; clears the front and current event valid bits, queue and output valid
module hid_to_ps2_scancode_tx_unit (
   input  logic        clock,
   input  logic        reset,
   h2ps_req_if.sink    req_if,
   h2ps_rsp_if.source  rsp_if
);
   import h2ps_pkg::*;

   // front to queue
   logic           q_push;
   h2ps_event_type q_push_data;
   logic           q_full;

   // queue to back
   logic           q_pop;
   h2ps_event_type q_pop_data;
   logic           q_empty;

   // keycode range check, rom lookup, drop of unmapped keys
   h2ps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full)
   );

   // decouples lookup from byte sequencing
   h2ps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // emits 0xe0 prefix if extended, 0xf0 break code on release, then the scan code, one per transaction
   h2ps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty),
      .rsp_if   (rsp_if)
   );

   // queue is never written while full nor read while empty
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full) && !(q_pop && q_empty))
      else $error("event queue overflow or underflow");

   // the frame always wraps the byte with start, odd parity and stop
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.frame_bits[8:1] == rsp_if.data_byte) &&
                       !rsp_if.frame_bits[0] && rsp_if.frame_bits[10] &&
                       (^rsp_if.frame_bits[9:1]))
      else $error("ps/2 frame does not match data byte");

   // only prefix bytes may come without last
   a_prefix_only: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.last |->
         (rsp_if.data_byte == PREFIX_EXT) || (rsp_if.data_byte == PREFIX_BREAK))
      else $error("non-final byte is not a prefix");

   // an extended prefix is followed by a break code or the final byte
   a_ext_then: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last &&
      (rsp_if.data_byte == PREFIX_EXT) |=> !(rsp_if.valid && (rsp_if.data_byte == PREFIX_EXT) &&
                                            !rsp_if.last))
      else $error("extended prefix repeated");
endmodule

FILE: rtl/h2ps_front.sv
// front end: accepts key events, translates the keycode and drops unmapped keys
module h2ps_front (
   input  logic                    clock,
   input  logic                    reset,
   h2ps_req_if.sink                req_if,
   output logic                    push,
   output h2ps_pkg::h2ps_event_type push_data,
   input  logic                    full
);
   import h2ps_pkg::*;

   logic                   ev_valid_ff, ev_valid_in;
   h2ps_event_type         ev_ff, ev_in;
   logic                   accept;
   logic                   in_a, in_b, mapped;
   logic [ROM_A_IDX_W-1:0] idx_a;
   logic [ROM_B_IDX_W-1:0] idx_b;
   logic [ENTRY_W-1:0]     entry;

   assign in_b  = (req_if.keycode >= ROM_B_FIRST) && (req_if.keycode <= ROM_B_LAST);
   assign in_a  = (req_if.keycode >= ROM_A_FIRST) && (req_if.keycode <= ROM_A_LAST);
   assign idx_a = ROM_A_IDX_W'(req_if.keycode - ROM_A_FIRST);
   assign idx_b = ROM_B_IDX_W'(req_if.keycode - ROM_B_FIRST);

   always_comb begin
      entry = NO_CODE;
      if (in_b) begin
         entry = ROM_B[idx_b];
      end else if (in_a) begin
         entry = ROM_A[idx_a];
      end
   end

   assign mapped = (in_a || in_b) && (entry != NO_CODE);

   assign push          = ev_valid_ff && !full;
   assign push_data     = ev_ff;
   assign req_if.ready  = !ev_valid_ff || !full;
   assign accept        = req_if.valid && req_if.ready;

   always_comb begin
      ev_valid_in = ev_valid_ff;
      ev_in       = ev_ff;
      if (accept) begin
         ev_valid_in = mapped;
         ev_in.ext   = entry[ENTRY_W-1];
         ev_in.brk   = !req_if.pressed;
         ev_in.code  = entry[BYTE_W-1:0];
      end else if (push) begin
         ev_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= ev_valid_in;
      end
      ev_ff <= ev_in;
   end
endmodule

FILE: rtl/h2ps_queue.sv
// small fifo of classified events between the front and back ends
module h2ps_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  h2ps_pkg::h2ps_event_type push_data,
   output logic                    full,
   input  logic                    pop,
   output h2ps_pkg::h2ps_event_type pop_data,
   output logic                    empty
);
   import h2ps_pkg::*;

   h2ps_event_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/h2ps_back.sv
// back end: walks one event through its prefix and code bytes into the output register
module h2ps_back (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    pop,
   input  h2ps_pkg::h2ps_event_type pop_data,
   input  logic                    empty,
   h2ps_rsp_if.source              rsp_if
);
   import h2ps_pkg::*;

   logic                cur_valid_ff, cur_valid_in;
   h2ps_event_type      cur_ff, cur_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [FRAME_W-1:0]  out_frame_ff, out_frame_in;
   logic                out_last_ff, out_last_in;
   logic                emit, final_byte;
   logic [BYTE_W-1:0]   next_byte;

   assign emit       = cur_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign final_byte = !cur_ff.ext && !cur_ff.brk;
   assign pop        = !empty && (!cur_valid_ff || (emit && final_byte));

   always_comb begin
      if (cur_ff.ext) begin
         next_byte = PREFIX_EXT;
      end else if (cur_ff.brk) begin
         next_byte = PREFIX_BREAK;
      end else begin
         next_byte = cur_ff.code;
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = pop_data;
      end else if (emit) begin
         if (final_byte) begin
            cur_valid_in = 1'b0;
         end else if (cur_ff.ext) begin
            cur_in.ext = 1'b0;
         end else begin
            cur_in.brk = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_frame_in = out_frame_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = next_byte;
         out_frame_in = make_frame(next_byte);
         out_last_in  = final_byte;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff       <= cur_in;
      out_byte_ff  <= out_byte_in;
      out_frame_ff <= out_frame_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.data_byte  = out_byte_ff;
   assign rsp_if.frame_bits = out_frame_ff;
   assign rsp_if.last       = out_last_ff;
endmodule

FILE: test/tb.sv
// self-checking testbench for the hid keycode to ps/2 set 2 scan code transmitter
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // ------------------------------------------------------------------
   // constants of the key translation, kept apart from the design's own
   // ------------------------------------------------------------------
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          DRAIN_CYCLES   = 20;
   localparam int          LO_MAP_SIZE    = 145;
   localparam int          HI_MAP_SIZE    = 44;
   localparam logic [15:0] LO_MAP_BASE    = 16'h0004;
   localparam logic [15:0] HI_MAP_BASE    = 16'h00E0;
   localparam logic [7:0]  SC_EXTENDED    = 8'hE0;
   localparam logic [7:0]  SC_RELEASE     = 8'hF0;
   localparam logic [8:0]  NO_SCAN_CODE   = 9'h000;
   localparam int          HOLD_OFF_LONG  = 100;

   // set 2 codes for hid usages 0x04..0x94; bit 8 flags the extended prefix
   localparam logic [8:0] LO_KEY_MAP [LO_MAP_SIZE] = '{
      9'h01c, 9'h032, 9'h021, 9'h023, 9'h024, 9'h02b, 9'h034, 9'h033, 9'h043, 9'h03b,
      9'h042, 9'h04b, 9'h03a, 9'h031, 9'h044, 9'h04d, 9'h015, 9'h02d, 9'h01b, 9'h02c,
      9'h03c, 9'h02a, 9'h01d, 9'h022, 9'h035, 9'h01a, 9'h016, 9'h01e, 9'h026, 9'h025,
      9'h02e, 9'h036, 9'h03d, 9'h03e, 9'h046, 9'h045, 9'h05a, 9'h076, 9'h066, 9'h00d,
      9'h029, 9'h04e, 9'h055, 9'h054, 9'h05b, 9'h05d, 9'h05d, 9'h04c, 9'h052, 9'h00e,
      9'h041, 9'h049, 9'h04a, 9'h058, 9'h005, 9'h006, 9'h004, 9'h00c, 9'h003, 9'h00b,
      9'h083, 9'h00a, 9'h001, 9'h009, 9'h078, 9'h007, 9'h17c, 9'h07e, 9'h17e, 9'h170,
      9'h16c, 9'h17d, 9'h171, 9'h179, 9'h17a, 9'h174, 9'h16b, 9'h172, 9'h175, 9'h077,
      9'h14a, 9'h07c, 9'h07b, 9'h079, 9'h15a, 9'h069, 9'h072, 9'h07a, 9'h06b, 9'h073,
      9'h074, 9'h06c, 9'h075, 9'h07d, 9'h070, 9'h071, 9'h061, 9'h12f, 9'h137, 9'h00f,
      9'h008, 9'h010, 9'h018, 9'h020, 9'h028, 9'h030, 9'h038, 9'h040, 9'h048, 9'h050,
      9'h057, 9'h05f, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h06d,
      9'h000, 9'h051, 9'h013, 9'h06a, 9'h064, 9'h067, 9'h027, 9'h000, 9'h000, 9'h000,
      9'h0f2, 9'h0f1, 9'h063, 9'h062, 9'h05f
   };

   // set 2 codes for the modifier and vendor usages 0xe0..0x10b
   localparam logic [8:0] HI_KEY_MAP [HI_MAP_SIZE] = '{
      9'h014, 9'h012, 9'h011, 9'h11f, 9'h114, 9'h059, 9'h111, 9'h127,
      9'h000, 9'h14d, 9'h115, 9'h13b, 9'h134, 9'h123, 9'h000, 9'h000,
      9'h132, 9'h121, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h150, 9'h148, 9'h12b, 9'h140, 9'h110, 9'h13a, 9'h138, 9'h130, 9'h128, 9'h120,
      9'h000, 9'h047, 9'h04f, 9'h065, 9'h068, 9'h06e, 9'h147, 9'h14f, 9'h165, 9'h167,
      9'h168, 9'h16a
   };

   // one byte on the wire as the receiver should see it
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [10:0] frame_bits;
      logic        last;
   } scan_byte_type;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } rsp_stall_mode_type;

   // ------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   h2ps_req_if req_ch ();
   h2ps_rsp_if rsp_ch ();

   hid_to_ps2_scancode_tx_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // ------------------------------------------------------------------
   // shared bench state
   // ------------------------------------------------------------------
   scan_byte_type expected_scan_bytes [$];   // bytes still owed by the block
   int         mismatch_count    = 0;
   int         mapped_events     = 0;     // events that owe at least one byte
   int         cycle_count       = 0;
   int         rsp_hold_left     = 0;     // long hold-off asked by a test
   bit         sender_gaps_on    = 1'b1;
   int         sender_burst_left = 0;

   // ------------------------------------------------------------------
   // key translation predictor
   // ------------------------------------------------------------------

   // table entry for a keycode, or no code when outside both tables
   function automatic logic [8:0] key_map_entry(input logic [15:0] key);
      if (key >= HI_MAP_BASE && key < HI_MAP_BASE + HI_MAP_SIZE)
         return HI_KEY_MAP[key - HI_MAP_BASE];
      if (key >= LO_MAP_BASE && key < LO_MAP_BASE + LO_MAP_SIZE)
         return LO_KEY_MAP[key - LO_MAP_BASE];
      return NO_SCAN_CODE;
   endfunction

   // ps/2 frame: start 0, data lsb first, odd parity, stop 1
   function automatic logic [10:0] ps2_frame(input logic [7:0] b);
      int   ones;
      logic odd_bit;
      ones = 0;
      for (int i = 0; i < 8; i++)
         ones += b[i];
      odd_bit = (ones % 2 == 0);
      return {1'b1, odd_bit, b, 1'b0};
   endfunction

   function automatic void owe_scan_byte(input logic [7:0] b, input logic is_last);
      scan_byte_type sb;
      sb.data_byte  = b;
      sb.frame_bits = ps2_frame(b);
      sb.last       = is_last;
      expected_scan_bytes.push_back(sb);
   endfunction

   // bytes a key event should produce: optional e0, optional f0, then the code
   function automatic void predict_scan_bytes(input logic [15:0] key, input logic is_press);
      logic [8:0] entry;
      entry = key_map_entry(key);
      if (entry == NO_SCAN_CODE)
         return;
      mapped_events++;
      if (entry[8])
         owe_scan_byte(SC_EXTENDED, 1'b0);
      if (!is_press)
         owe_scan_byte(SC_RELEASE, 1'b0);
      owe_scan_byte(entry[7:0], 1'b1);
   endfunction

   // random keycode that has a scan code, weighted toward the main table
   function automatic logic [15:0] random_mapped_key();
      logic [15:0] key;
      do begin
         if ($urandom_range(0, 3) == 0)
            key = HI_MAP_BASE + 16'($urandom_range(0, HI_MAP_SIZE - 1));
         else
            key = LO_MAP_BASE + 16'($urandom_range(0, LO_MAP_SIZE - 1));
      end while (key_map_entry(key) == NO_SCAN_CODE);
      return key;
   endfunction

   // ------------------------------------------------------------------
   // mismatch reporting and result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // every rsp transaction is matched against the oldest owed byte
   always @(posedge clock) begin
      scan_byte_type wanted;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_scan_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_ch.data_byte));
         end else begin
            wanted = expected_scan_bytes.pop_front();
            if (rsp_ch.data_byte !== wanted.data_byte)
               report_mismatch($sformatf("data_byte got %02h want %02h",
                                         rsp_ch.data_byte, wanted.data_byte));
            if (rsp_ch.frame_bits !== wanted.frame_bits)
               report_mismatch($sformatf("frame_bits got %03h want %03h for byte %02h",
                                         rsp_ch.frame_bits, wanted.frame_bits,
                                         wanted.data_byte));
            if (rsp_ch.last !== wanted.last)
               report_mismatch($sformatf("last got %b want %b for byte %02h",
                                         rsp_ch.last, wanted.last, wanted.data_byte));
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stall patterns, each held for a random span, plus a
   // long hold-off on request so the event queue fills and req stalls
   // ------------------------------------------------------------------
   initial begin
      rsp_stall_mode_type stall_mode;
      int                 mode_left;
      int                 phase;
      rsp_ch.ready = 1'b0;
      stall_mode   = STALL_NONE;
      mode_left    = 0;
      phase        = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = rsp_stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:     rsp_ch.ready <= 1'b1;
               STALL_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               STALL_PERIODIC: rsp_ch.ready <= (phase % 5) > 1;
               default:        rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // sender: one key event per call, entered and left at a falling edge;
   // in gap mode it works in random bursts with idle cycles between them
   // ------------------------------------------------------------------
   task automatic send_key_event(input logic [15:0] key, input logic is_press);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.keycode <= key;
      req_ch.pressed <= is_press;
      // wait for the req transaction
      do
         @(posedge clock);
      while (!req_ch.ready);
      predict_scan_bytes(key, is_press);
      @(negedge clock);
      if (sender_gaps_on) begin
         if (sender_burst_left > 0)
            sender_burst_left--;
         if (sender_burst_left == 0) begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
            sender_burst_left = $urandom_range(1, 10);
         end
      end
   endtask

   // press and release, sometimes rolling over onto a second key
   task automatic type_stroke();
      logic [15:0] first_key;
      logic [15:0] second_key;
      first_key = random_mapped_key();
      send_key_event(first_key, 1'b1);
      if ($urandom_range(0, 2) == 0) begin
         second_key = random_mapped_key();
         send_key_event(second_key, 1'b1);
         send_key_event(first_key, 1'b0);
         send_key_event(second_key, 1'b0);
      end else begin
         send_key_event(first_key, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // table bounds, unmapped keycodes, holes in both tables, byte extremes
   task automatic test_table_edges();
      send_key_event(16'h0000, 1'b1);   // all-zero keycode, below the tables
      send_key_event(16'h0003, 1'b0);   // just below the main table
      send_key_event(16'h0004, 1'b1);   // first entry of the main table
      send_key_event(16'h0004, 1'b0);
      send_key_event(16'h0094, 1'b1);   // last entry of the main table
      send_key_event(16'h0094, 1'b0);
      send_key_event(16'h0095, 1'b1);   // gap between the tables
      send_key_event(16'h00DF, 1'b0);
      send_key_event(16'h00E0, 1'b1);   // first modifier entry
      send_key_event(16'h00E0, 1'b0);
      send_key_event(16'h010B, 1'b1);   // last modifier entry, extended
      send_key_event(16'h010B, 1'b0);
      send_key_event(16'h010C, 1'b1);   // just past the modifier table
      send_key_event(16'hFFFF, 1'b0);   // all-ones keycode
      send_key_event(16'h1004, 1'b1);   // high usage bits make it unmapped
      send_key_event(16'h0074, 1'b1);   // hole in the main table
      send_key_event(16'h00E8, 1'b0);   // hole in the modifier table
      send_key_event(16'h0042, 1'b1);   // smallest scan code byte
      send_key_event(16'h0090, 1'b0);   // largest scan code byte
   endtask

   // extended make gives two bytes, extended break three
   task automatic test_extended_keys();
      send_key_event(16'h0046, 1'b1);
      send_key_event(16'h0046, 1'b0);
      send_key_event(16'h00E3, 1'b1);
      send_key_event(16'h00E3, 1'b0);
      send_key_event(16'h0058, 1'b1);
      send_key_event(16'h0058, 1'b0);
   endtask

   // receiver holds off while events keep coming back to back
   task automatic test_queue_backpressure();
      sender_gaps_on = 1'b0;
      rsp_hold_left  = HOLD_OFF_LONG;
      for (int i = 0; i < 20; i++)
         send_key_event(random_mapped_key(), 1'($urandom_range(0, 1)));
      sender_gaps_on = 1'b1;
   endtask

   // realistic typing with bursty sender
   task automatic test_random_typing(input int target_events);
      int goal;
      goal = mapped_events + target_events;
      while (mapped_events < goal)
         type_stroke();
   endtask

   // back-to-back typing, no sender gaps
   task automatic test_streaming_typing(input int target_events);
      int goal;
      goal = mapped_events + target_events;
      sender_gaps_on = 1'b0;
      while (mapped_events < goal)
         type_stroke();
      sender_gaps_on = 1'b1;
   endtask

   // typing mixed with noise keycodes, orphan releases and repeated presses
   task automatic test_noise_and_broken(input int target_events);
      int          goal;
      int          pick;
      logic [15:0] key;
      goal = mapped_events + target_events;
      while (mapped_events < goal) begin
         pick = $urandom_range(0, 9);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         case (pick)
            0, 1: send_key_event(16'($urandom()), 1'($urandom_range(0, 1)));
            2:    send_key_event(16'($urandom_range(0, 16'h010F)), 1'($urandom_range(0, 1)));
            3:    send_key_event(random_mapped_key(), 1'b0);
            4: begin
               key = random_mapped_key();
               send_key_event(key, 1'b1);
               send_key_event(key, 1'b1);
            end
            default: type_stroke();
         endcase
      end
      sender_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hid_to_ps2_scancode_tx_unit regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.keycode = 16'h0000;
      req_ch.pressed = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_table_edges();
      test_extended_keys();
      test_queue_backpressure();
      test_random_typing(200);
      test_streaming_typing(100);
      test_noise_and_broken(80);

      // stop offering and let every owed byte come out
      req_ch.valid <= 1'b0;
      while (expected_scan_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("hid_to_ps2_scancode_tx_unit regression: pass");
      else
         $display("hid_to_ps2_scancode_tx_unit regression: fail");
      $finish;
   end

endmodule
